>>> src/vdc_pkg.sv
// shared types and constants for the varint decoder
package vdc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_W      = 64;
    localparam int BYTE_W     = 8;
    localparam int DIGIT_BITS = 7;
    localparam int POS_W      = 4;
    localparam int SHIFT_W    = 7;
    localparam int ROOM_W     = 8;
    localparam int STATUS_W   = 2;

    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;
    localparam int                CONT_BIT  = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_INVALID  = 2'd2
    } vdc_status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } vdc_byte_t;

endpackage

>>> src/varint_decoder_checked_unit.sv
// top level of the unsigned 64-bit varint decoder with overflow and minimality checks
//
//  channel  direction  payload                              handshake
//  in       request    in_byte                              in_valid / in_stall
//  out      result     decoded_value, status, bytes_used    out_valid / out_stall
//
//  one byte per cycle while no result stalls; final byte -> input reg -> result reg
//  the decode state update is a single pass through shift, mask and or logic
//  reset clears the decode state and both valid flags
//  a stalled result holds the output register; the input register keeps taking
//  bytes until it is full, then in_stall rises
module varint_decoder_checked_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vdc_pkg::BYTE_W-1:0]    in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vdc_pkg::OUT_W-1:0]     decoded_value,
    output logic [vdc_pkg::STATUS_W-1:0]  status,
    output logic [vdc_pkg::POS_W-1:0]     bytes_used
);

    vdc_pkg::vdc_byte_t held;
    logic               advance;

    vdc_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .advance  (advance),
        .held     (held)
    );

    vdc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .held          (held),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_value (decoded_value),
        .status        (status),
        .bytes_used    (bytes_used)
    );

endmodule

>>> src/vdc_in_reg.sv
// input register that holds one request byte until the core takes it
module vdc_in_reg
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [vdc_pkg::BYTE_W-1:0] in_byte,
    output logic                      in_stall,
    input  logic                      advance,
    output vdc_pkg::vdc_byte_t        held
);

    logic                       valid_reg;
    logic [vdc_pkg::BYTE_W-1:0] data_reg;

    assign in_stall   = valid_reg && !advance;
    assign held.valid = valid_reg;
    assign held.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= in_byte;
        end
    end

endmodule

>>> src/vdc_core.sv
// decode state, per-byte decode logic and result register
module vdc_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  vdc_pkg::vdc_byte_t            held,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vdc_pkg::OUT_W-1:0]     decoded_value,
    output logic [vdc_pkg::STATUS_W-1:0]  status,
    output logic [vdc_pkg::POS_W-1:0]     bytes_used
);

    localparam int VB = vdc_pkg::VALUE_BITS;

    logic [VB-1:0]                 acc_reg;
    logic [VB-1:0]                 acc_next;
    logic [vdc_pkg::POS_W-1:0]     pos_reg;
    logic [vdc_pkg::POS_W-1:0]     pos_next;
    logic                          out_valid_reg;
    logic [vdc_pkg::OUT_W-1:0]     value_reg;
    logic [vdc_pkg::OUT_W-1:0]     value_next;
    vdc_pkg::vdc_status_t          status_reg;
    vdc_pkg::vdc_status_t          status_next;
    logic [vdc_pkg::POS_W-1:0]     used_reg;

    logic [vdc_pkg::SHIFT_W-1:0]   shift;
    logic [vdc_pkg::ROOM_W-1:0]    shift_ext;
    logic [vdc_pkg::ROOM_W-1:0]    room;
    logic                          over_pos;
    logic                          near_top;
    logic                          overflow;
    logic                          last_byte;
    logic                          emit;
    logic [VB+vdc_pkg::DIGIT_BITS-1:0] digit_wide;
    logic [VB-1:0]                 acc_merged;
    logic [vdc_pkg::POS_W-1:0]     used;
    logic [vdc_pkg::BYTE_W-1:0]    piece;

    assign piece   = held.data;
    assign advance = held.valid && (!out_valid_reg || !out_stall);

    assign shift     = vdc_pkg::SHIFT_W'(pos_reg) * vdc_pkg::SHIFT_W'(vdc_pkg::DIGIT_BITS);
    assign shift_ext = vdc_pkg::ROOM_W'(shift);
    assign room      = vdc_pkg::ROOM_W'(VB) - shift_ext;
    assign over_pos  = shift_ext >= vdc_pkg::ROOM_W'(VB);
    assign near_top  = (shift_ext + vdc_pkg::ROOM_W'(vdc_pkg::DIGIT_BITS))
                       >= vdc_pkg::ROOM_W'(VB);
    assign overflow  = over_pos || (near_top && ((piece >> room[3:0]) != '0));

    assign digit_wide = (VB + vdc_pkg::DIGIT_BITS)'(piece & vdc_pkg::LOW7_MASK) << shift;
    assign acc_merged = acc_reg | digit_wide[VB-1:0];
    assign last_byte  = !piece[vdc_pkg::CONT_BIT];
    assign used       = pos_reg + vdc_pkg::POS_W'(1);
    assign emit       = overflow || last_byte;

    always_comb
    begin
        acc_next    = acc_merged;
        pos_next    = used;
        value_next  = '0;
        status_next = vdc_pkg::ST_OK;
        if (overflow)
        begin
            acc_next    = '0;
            pos_next    = '0;
            status_next = vdc_pkg::ST_OVERFLOW;
        end
        else if (last_byte)
        begin
            acc_next = '0;
            pos_next = '0;
            if (piece == '0 && pos_reg != '0)
            begin
                status_next = vdc_pkg::ST_INVALID;
            end
            else
            begin
                value_next = vdc_pkg::OUT_W'(acc_merged);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg <= acc_next;
                pos_reg <= pos_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            used_reg   <= used;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign status        = status_reg;
    assign bytes_used    = used_reg;

endmodule
